### hw/rtl/mlq_pkg.sv
// ----------------------------------------------------------------------------
// mlq_pkg
// Shared types, codes and helpers of the three-level feedback queue table.
// ----------------------------------------------------------------------------
package mlq_pkg;

  localparam int unsigned MLQ_MAX_TASKS = 8;

  localparam int unsigned HANDLE_W  = 16;
  localparam int unsigned LEVEL_W   = 2;
  localparam int unsigned TICK_W    = 32;
  localparam int unsigned QUANTUM_W = 16;

  typedef logic [2:0] action_t;
  localparam action_t ACT_REGISTER = 3'd0;
  localparam action_t ACT_EXPIRE   = 3'd1;
  localparam action_t ACT_PROMOTE  = 3'd2;
  localparam action_t ACT_TICK     = 3'd3;
  localparam action_t ACT_QUERY    = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_FULL     = 2'd1;
  localparam status_t ST_NOTFOUND = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

  typedef logic [LEVEL_W-1:0] level_t;
  localparam level_t LVL_HIGH   = 2'd0;
  localparam level_t LVL_MEDIUM = 2'd1;
  localparam level_t LVL_LOW    = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_QUANTUM_HIGH   = 2'd0;
  localparam cfg_idx_t CFG_QUANTUM_MEDIUM = 2'd1;
  localparam cfg_idx_t CFG_QUANTUM_LOW    = 2'd2;
  localparam cfg_idx_t CFG_BOOST_PERIOD   = 2'd3;

  localparam logic [QUANTUM_W-1:0] RST_QUANTUM_HIGH   = 16'd10;
  localparam logic [QUANTUM_W-1:0] RST_QUANTUM_MEDIUM = 16'd20;
  localparam logic [QUANTUM_W-1:0] RST_QUANTUM_LOW    = 16'd40;
  localparam logic [QUANTUM_W-1:0] RST_BOOST_PERIOD   = 16'd1000;

  typedef struct packed {
    action_t             action;
    logic [HANDLE_W-1:0] task_id;
    logic [2:0]          slot_index;
  } mlq_req_t;

  typedef struct packed {
    status_t              status;
    logic [2:0]           slot_out;
    logic [HANDLE_W-1:0]  handle_out;
    level_t               level_out;
    logic [QUANTUM_W-1:0] quantum_out;
    logic [TICK_W-1:0]    arrival_out;
    logic                 level_changed;
    logic                 boosted;
  } mlq_rsp_t;

  typedef struct packed {
    logic [QUANTUM_W-1:0] quantum_high;
    logic [QUANTUM_W-1:0] quantum_medium;
    logic [QUANTUM_W-1:0] quantum_low;
    logic [QUANTUM_W-1:0] boost_period;
  } mlq_cfg_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    level_t              level;
    logic [TICK_W-1:0]   arrival;
  } mlq_entry_t;

  function automatic logic [QUANTUM_W-1:0] level_quantum(input level_t lvl,
                                                         input mlq_cfg_t cfg);
    logic [QUANTUM_W-1:0] q;
    case (lvl)
      LVL_HIGH:   q = cfg.quantum_high;
      LVL_MEDIUM: q = cfg.quantum_medium;
      default:    q = cfg.quantum_low;
    endcase
    return q;
  endfunction

endpackage

### hw/rtl/mlq_ram.sv
// ----------------------------------------------------------------------------
// mlq_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlq_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mlq_cfg.sv
// ----------------------------------------------------------------------------
// mlq_cfg
// Configuration register file: three level quanta and the boost period.
// ----------------------------------------------------------------------------
module mlq_cfg import mlq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  cfg_idx_t             cfg_index_i,
  input  logic [QUANTUM_W-1:0] cfg_wdata_i,
  output mlq_cfg_t             cfg_o
);

  mlq_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_QUANTUM_HIGH:   cfg_d.quantum_high   = cfg_wdata_i;
        CFG_QUANTUM_MEDIUM: cfg_d.quantum_medium = cfg_wdata_i;
        CFG_QUANTUM_LOW:    cfg_d.quantum_low    = cfg_wdata_i;
        CFG_BOOST_PERIOD:   cfg_d.boost_period   = cfg_wdata_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quantum_high   <= RST_QUANTUM_HIGH;
      cfg_q.quantum_medium <= RST_QUANTUM_MEDIUM;
      cfg_q.quantum_low    <= RST_QUANTUM_LOW;
      cfg_q.boost_period   <= RST_BOOST_PERIOD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

endmodule

### hw/rtl/mlq_ctrl.sv
// ----------------------------------------------------------------------------
// mlq_ctrl
// Sequencer that walks the slot memory one entry per cycle for the items that scan it.
// ----------------------------------------------------------------------------
module mlq_ctrl import mlq_pkg::*; #(
  parameter int unsigned MaxTasks = MLQ_MAX_TASKS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mlq_cfg_t cfg_i,
  input  logic     start_i,
  input  mlq_req_t req_i,
  output logic     busy_o,
  output logic     done_o,
  output mlq_rsp_t rsp_o
);

  localparam int unsigned SlotW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned CntW  = $clog2(MaxTasks + 1);

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e              state_q, state_d;
  action_t             act_q, act_d;
  logic [HANDLE_W-1:0] handle_q, handle_d;
  logic [CntW-1:0]     rd_cnt_q, rd_cnt_d;
  logic                chk_vld_q, chk_vld_d;
  logic [SlotW-1:0]    chk_idx_q, chk_idx_d;
  logic                changed_q, changed_d;
  logic [MaxTasks-1:0] valid_q, valid_d;
  logic [TICK_W-1:0]   tick_q, tick_d;
  logic [TICK_W-1:0]   since_q, since_d;
  logic                done_q, done_d;
  mlq_rsp_t            rsp_q, rsp_d;

  logic             ram_we, ram_re;
  logic [SlotW-1:0] ram_raddr;
  mlq_entry_t       ram_wdata, ent;

  logic              start_ok;
  logic [TICK_W-1:0] since_inc;
  logic              boost_due;
  logic              ent_vld, chk_last, handle_hit, query_in_range;
  level_t            lvl_next;

  mlq_ram #(
    .Width ($bits(mlq_entry_t)),
    .Depth (MaxTasks)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (chk_idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ent)
  );

  assign start_ok       = start_i && (state_q == S_IDLE);
  assign since_inc      = since_q + 32'd1;
  assign boost_due      = since_inc >= {16'd0, cfg_i.boost_period};
  assign ent_vld        = valid_q[chk_idx_q];
  assign chk_last       = chk_idx_q == SlotW'(MaxTasks - 1);
  assign handle_hit     = ent_vld && (ent.handle == handle_q);
  assign query_in_range = 32'(req_i.slot_index) < 32'(MaxTasks);
  assign ram_raddr      = rd_cnt_q[SlotW-1:0];

  // demote saturates at low, promote stops at high
  always_comb begin
    lvl_next = ent.level;
    if (act_q == ACT_EXPIRE) begin
      if (ent.level < LVL_LOW) lvl_next = ent.level + 2'd1;
    end else begin
      if (ent.level != LVL_HIGH) lvl_next = ent.level - 2'd1;
    end
  end

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    handle_d  = handle_q;
    rd_cnt_d  = rd_cnt_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    changed_d = changed_q;
    valid_d   = valid_q;
    tick_d    = tick_q;
    since_d   = since_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = ent;

    case (state_q)
      S_IDLE: begin
        if (start_ok) begin
          act_d     = req_i.action;
          handle_d  = req_i.task_id;
          rd_cnt_d  = '0;
          changed_d = 1'b0;
          rsp_d     = '0;
          case (req_i.action)
            ACT_REGISTER, ACT_EXPIRE, ACT_PROMOTE: begin
              if (req_i.task_id == '0) begin
                rsp_d.status = ST_NOTFOUND;
                done_d       = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            ACT_TICK: begin
              tick_d       = tick_q + 32'd1;
              rsp_d.status = ST_OK;
              if (boost_due) begin
                since_d       = '0;
                rsp_d.boosted = 1'b1;
                state_d       = S_SCAN;
              end else begin
                since_d = since_inc;
                done_d  = 1'b1;
              end
            end
            ACT_QUERY: begin
              if (query_in_range) begin
                rd_cnt_d = CntW'(req_i.slot_index);
                state_d  = S_SCAN;
              end else begin
                rsp_d.status   = ST_EMPTY;
                rsp_d.slot_out = req_i.slot_index;
                done_d         = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // read of slot n overlaps the check of slot n-1
        ram_re    = rd_cnt_q < CntW'(MaxTasks);
        rd_cnt_d  = rd_cnt_q + CntW'(ram_re);
        chk_vld_d = ram_re;
        chk_idx_d = rd_cnt_q[SlotW-1:0];

        if (chk_vld_q) begin
          case (act_q)
            ACT_REGISTER: begin
              if (!ent_vld) begin
                ram_we              = 1'b1;
                ram_wdata.handle    = handle_q;
                ram_wdata.level     = LVL_HIGH;
                ram_wdata.arrival   = tick_q;
                valid_d[chk_idx_q]  = 1'b1;
                rsp_d.status        = ST_OK;
                rsp_d.slot_out      = 3'(chk_idx_q);
                rsp_d.handle_out    = handle_q;
                rsp_d.level_out     = LVL_HIGH;
                rsp_d.quantum_out   = level_quantum(LVL_HIGH, cfg_i);
                rsp_d.arrival_out   = tick_q;
                rsp_d.level_changed = 1'b1;
                state_d             = S_IDLE;
              end else if (chk_last) begin
                rsp_d.status = ST_FULL;
                state_d      = S_IDLE;
              end
            end
            ACT_EXPIRE, ACT_PROMOTE: begin
              if (handle_hit) begin
                ram_we              = lvl_next != ent.level;
                ram_wdata.level     = lvl_next;
                rsp_d.status        = ST_OK;
                rsp_d.slot_out      = 3'(chk_idx_q);
                rsp_d.handle_out    = ent.handle;
                rsp_d.level_out     = lvl_next;
                rsp_d.quantum_out   = level_quantum(lvl_next, cfg_i);
                rsp_d.arrival_out   = ent.arrival;
                rsp_d.level_changed = lvl_next != ent.level;
                state_d             = S_IDLE;
              end else if (chk_last) begin
                rsp_d.status = ST_NOTFOUND;
                state_d      = S_IDLE;
              end
            end
            ACT_TICK: begin
              if (ent_vld && (ent.level != LVL_HIGH)) begin
                ram_we          = 1'b1;
                ram_wdata.level = LVL_HIGH;
                changed_d       = 1'b1;
              end
              if (chk_last) begin
                rsp_d.level_changed = changed_d;
                state_d             = S_IDLE;
              end
            end
            ACT_QUERY: begin
              rsp_d.slot_out = 3'(chk_idx_q);
              if (ent_vld) begin
                rsp_d.status      = ST_OK;
                rsp_d.handle_out  = ent.handle;
                rsp_d.level_out   = ent.level;
                rsp_d.quantum_out = level_quantum(ent.level, cfg_i);
                rsp_d.arrival_out = ent.arrival;
              end else begin
                rsp_d.status = ST_EMPTY;
              end
              state_d = S_IDLE;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase

          if (state_d == S_IDLE) begin
            done_d    = 1'b1;
            chk_vld_d = 1'b0;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      act_q     <= ACT_REGISTER;
      handle_q  <= '0;
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
      chk_idx_q <= '0;
      changed_q <= 1'b0;
      valid_q   <= '0;
      tick_q    <= '0;
      since_q   <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      state_q   <= state_d;
      act_q     <= act_d;
      handle_q  <= handle_d;
      rd_cnt_q  <= rd_cnt_d;
      chk_vld_q <= chk_vld_d;
      chk_idx_q <= chk_idx_d;
      changed_q <= changed_d;
      valid_q   <= valid_d;
      tick_q    <= tick_d;
      since_q   <= since_d;
      done_q    <= done_d;
      rsp_q     <= rsp_d;
    end
  end

  assign busy_o = state_q != S_IDLE;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_start_leads_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_ok |=> (state_q == S_SCAN) || done_q)
    else $error("accepted item neither scanning nor answered");

  a_write_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_SCAN) && chk_vld_q)
    else $error("slot write outside a checked scan step");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (rsp_q.status == ST_FULL)) |-> (&valid_q))
    else $error("table full reported with a free slot");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (rd_cnt_q <= CntW'(MaxTasks)))
    else $error("scan counter past table depth");

endmodule

### hw/rtl/mlfq_level_table_unit.sv
// ----------------------------------------------------------------------------
// mlfq_level_table_unit
// Three-level feedback queue level table with register, demote, promote,
// tick/boost and query actions.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low; its single result
// appears on rsp_o, where it stays until the next item is taken, with done_o
// high for exactly one cycle, and cannot be stalled. Ticks without a boost,
// zero handles, out-of-range queries and unused actions answer without
// raising busy_o: done_o rises in the cycle after acceptance. Register,
// demote, promote and boosting ticks walk the slot memory through its single
// read port, one slot per cycle with the read of the next slot overlapping
// the check of the current one; a walk ends at the slot that settles the
// item or at the last slot, a query reads only its slot. done_o rises in
// the same cycle in which busy_o falls. Configuration is always ready.
module mlfq_level_table_unit import mlq_pkg::*; #(
  parameter int unsigned MaxTasks = MLQ_MAX_TASKS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  mlq_req_t             req_i,
  output logic                 busy_o,
  output logic                 done_o,
  output mlq_rsp_t             rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  cfg_idx_t             cfg_index_i,
  input  logic [QUANTUM_W-1:0] cfg_wdata_i
);

  mlq_cfg_t cfg;

  mlq_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mlq_ctrl #(
    .MaxTasks (MaxTasks)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .start_i (start_i),
    .req_i   (req_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .rsp_o   (rsp_o)
  );

endmodule
